// ----- rtl/sscu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the serial stepper command unit.
// No dependencies; imported by sscu_parser and serial_stepper_command_unit.
package sscu_pkg;

  localparam int MaxStepsW  = 16;
  localparam int HalfPerW   = 16;
  localparam int TrigLenW   = 20;
  localparam int CfgDataW   = 20;
  localparam int CfgIndexW  = 2;
  localparam int MagW       = 17;

  localparam logic [MaxStepsW-1:0] MAX_STEPS_RST = 16'd800;
  localparam logic [HalfPerW-1:0]  HALF_PER_RST  = 16'd100;
  localparam logic [TrigLenW-1:0]  TRIG_LEN_RST  = 20'd75000;
  localparam logic [MagW-1:0]      MAG_MAX       = 17'd131071;

  localparam logic [CfgIndexW-1:0] REG_MAX_STEPS = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_HALF_PER  = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_TRIG_LEN  = 2'd2;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_D_LO    = 8'h64;
  localparam logic [7:0] CH_D_UP    = 8'h44;
  localparam logic [7:0] CH_E_LO    = 8'h65;
  localparam logic [7:0] CH_E_UP    = 8'h45;
  localparam logic [7:0] CH_T_LO    = 8'h74;
  localparam logic [7:0] CH_T_UP    = 8'h54;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ONE     = 8'h31;

  typedef struct packed {
    logic keep;   // offer a character to the number buffer
    logic clear;  // empty the buffer and restart the parse
  } parse_ctl_t;

  typedef struct packed {
    logic       busy_res;
    logic       trigger_level;
    logic       enable_level;
    logic       dir_level;
    logic       step_level;
    logic       byte_taken;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

endpackage

// ----- rtl/sscu_parser.sv -----
`timescale 1ns / 1ps
// Number buffer and integer parser: leading whitespace, optional sign, digits.
// Depends on sscu_pkg.
module sscu_parser #(
  parameter int BUFFER_CHARS = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sscu_pkg::parse_ctl_t      ctl,
  input  logic [7:0]                ch,
  output logic [sscu_pkg::MagW-1:0] magnitude,
  output logic                      negative_sign
);
  import sscu_pkg::*;

  localparam int CountW = $clog2(BUFFER_CHARS + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(BUFFER_CHARS);

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  phase_t             phase, phase_next;
  logic [CountW-1:0]  stored_count;
  logic [MagW-1:0]    magnitude_next;
  logic               negative_next;
  logic               is_digit, is_space, take;
  logic [20:0]        mag_x10;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign take     = ctl.keep && (stored_count < CountMax);
  assign mag_x10  = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0}
                    + {17'd0, 4'(ch - CH_ZERO)};

  always_comb begin
    phase_next     = phase;
    magnitude_next = magnitude;
    negative_next  = negative_sign;
    if (phase != PH_STOP) begin
      if (phase == PH_SKIP && is_space) begin
        phase_next = PH_SKIP;
      end else if (phase == PH_SKIP && ch == CH_PLUS) begin
        phase_next = PH_SIGN;
      end else if (phase == PH_SKIP && ch == CH_MINUS) begin
        phase_next    = PH_SIGN;
        negative_next = 1'b1;
      end else if (is_digit) begin
        phase_next     = PH_DIGITS;
        magnitude_next = (mag_x10 > {4'd0, MAG_MAX}) ? MAG_MAX : mag_x10[MagW-1:0];
      end else begin
        phase_next = PH_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      phase         <= PH_SKIP;
      stored_count  <= '0;
      magnitude     <= '0;
      negative_sign <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      stored_count  <= stored_count + 1'b1;
      magnitude     <= magnitude_next;
      negative_sign <= negative_next;
    end
  end

endmodule

// ----- rtl/serial_stepper_command_unit.sv -----
`timescale 1ns / 1ps
// Serial stepper command unit: command decode, step and trigger timing, result register.
// Depends on sscu_pkg and sscu_parser.
//
//   channel  dir  handshake           contents
//   s_*      in   tvalid/tready       tuser: kind; tdata: rx_byte
//   m_*      out  tvalid/tready       tdata: result fields
//   cfg_*    in   cfg_we              cfg_index, cfg_data
//
// One transaction per cycle while m_tready allows; each result shows in the cycle after its input is accepted.
// A valid result holds while m_tready is low; s_tready follows m_tready while a result is valid.
// Reset is synchronous; registers other than the result data return to their default values.
module serial_stepper_command_unit #(
  parameter int BUFFER_CHARS = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  input  logic [1:0]                     s_tuser,   // [1:0] kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] byte_taken, [10] step_level, [11] dir_level,
  // [12] enable_level, [13] trigger_level, [14] busy_res, [15] zero
  output logic [15:0]                    m_tdata,
  input  logic                           cfg_we,
  input  logic [sscu_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [sscu_pkg::CfgDataW-1:0]  cfg_data
);
  import sscu_pkg::*;

  logic [MaxStepsW-1:0] max_steps;
  logic [HalfPerW-1:0]  step_half_period;
  logic [TrigLenW-1:0]  trigger_length;

  logic [15:0]          steps_left, steps_left_next;
  logic [HalfPerW-1:0]  step_timer, step_timer_next, hp, st_dec;
  logic                 step_out, step_out_next;
  logic                 dir_out, dir_out_next;
  logic                 enable_out, enable_out_next;
  logic [TrigLenW-1:0]  trigger_timer, trigger_timer_next;
  logic                 trigger_out, trigger_out_next;

  logic                 acc, busy, byte_ok;
  logic [7:0]           ch;
  logic [1:0]           kind;
  parse_ctl_t           pctl;
  logic [MagW-1:0]      magnitude;
  logic                 negative_sign;
  result_t              res;
  logic                 out_valid;
  result_t              out_res;

  assign s_tready = !out_valid || m_tready;
  assign acc      = s_tvalid && s_tready;
  assign ch       = s_tdata;
  assign kind     = s_tuser;
  assign busy     = (steps_left != '0) || (trigger_timer != '0);
  assign byte_ok  = (kind == KIND_BYTE) && !busy;
  assign hp       = (step_half_period == '0) ? HalfPerW'(1) : step_half_period;
  assign st_dec   = (step_timer != '0) ? step_timer - 1'b1 : '0;

  always_comb begin
    pctl.clear = acc && byte_ok && (ch == CH_NEWLINE);
    pctl.keep  = acc && byte_ok && (ch != CH_NEWLINE)
                 && (ch != CH_D_LO) && (ch != CH_D_UP)
                 && (ch != CH_E_LO) && (ch != CH_E_UP)
                 && (ch != CH_T_LO) && (ch != CH_T_UP);
  end

  sscu_parser #(
    .BUFFER_CHARS (BUFFER_CHARS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .ctl           (pctl),
    .ch            (ch),
    .magnitude     (magnitude),
    .negative_sign (negative_sign)
  );

  always_comb begin
    steps_left_next    = steps_left;
    step_timer_next    = step_timer;
    step_out_next      = step_out;
    dir_out_next       = dir_out;
    enable_out_next    = enable_out;
    trigger_timer_next = trigger_timer;
    trigger_out_next   = trigger_out;
    res                = '0;
    if (byte_ok) begin
      res.tx_valid   = 1'b1;
      res.tx_byte    = ch;
      res.byte_taken = 1'b1;
      priority if (ch == CH_NEWLINE) begin
        if (magnitude <= {1'b0, max_steps}) begin
          dir_out_next    = !((magnitude != '0) && !negative_sign);
          steps_left_next = magnitude[15:0];
          if (magnitude[15:0] != '0) begin
            step_out_next   = 1'b1;
            step_timer_next = hp;
          end
        end
      end else if (ch == CH_D_LO || ch == CH_D_UP) begin
        enable_out_next = 1'b0;
      end else if (ch == CH_E_LO || ch == CH_E_UP) begin
        enable_out_next = 1'b1;
      end else if (ch == CH_T_LO || ch == CH_T_UP) begin
        trigger_out_next   = 1'b1;
        trigger_timer_next = (trigger_length == '0) ? TrigLenW'(1) : trigger_length;
      end else begin
        // kept characters go to the parser
      end
    end else if (kind == KIND_TICK) begin
      if (steps_left != '0) begin
        step_timer_next = st_dec;
        if (st_dec == '0) begin
          if (step_out) begin
            step_out_next   = 1'b0;
            step_timer_next = hp;
          end else begin
            steps_left_next = steps_left - 1'b1;
            if (steps_left != 16'd1) begin
              step_out_next   = 1'b1;
              step_timer_next = hp;
            end
          end
        end
      end
      if (trigger_timer != '0) begin
        trigger_timer_next = trigger_timer - 1'b1;
        if (trigger_timer == TrigLenW'(1)) begin
          trigger_out_next = 1'b0;
        end
      end
    end else if (kind == KIND_DONE) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = CH_ONE;
    end
    res.step_level    = step_out_next;
    res.dir_level     = dir_out_next;
    res.enable_level  = enable_out_next;
    res.trigger_level = trigger_out_next;
    res.busy_res      = (steps_left_next != '0) || (trigger_timer_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps        <= MAX_STEPS_RST;
      step_half_period <= HALF_PER_RST;
      trigger_length   <= TRIG_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_STEPS) max_steps <= cfg_data[MaxStepsW-1:0];
      if (cfg_index == REG_HALF_PER) step_half_period <= cfg_data[HalfPerW-1:0];
      if (cfg_index == REG_TRIG_LEN) trigger_length <= cfg_data[TrigLenW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left    <= '0;
      step_timer    <= '0;
      step_out      <= 1'b0;
      dir_out       <= 1'b0;
      enable_out    <= 1'b1;
      trigger_timer <= '0;
      trigger_out   <= 1'b0;
    end else if (acc) begin
      steps_left    <= steps_left_next;
      step_timer    <= step_timer_next;
      step_out      <= step_out_next;
      dir_out       <= dir_out_next;
      enable_out    <= enable_out_next;
      trigger_timer <= trigger_timer_next;
      trigger_out   <= trigger_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};

endmodule

// ----- rtl/sscu_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the serial stepper command unit, bound to the top level.
// Depends only on the top-level ports.
module sscu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_ready_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused with no pending result");

  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0 && !m_tdata[9])
    else $error("transmit byte set without transmit");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted transaction has no result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind serial_stepper_command_unit sscu_checker u_sscu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/serial_stepper_command_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for serial_stepper_command_unit: command text, ticks and
// move-done events in, one output snapshot per event checked against a cycle-free model.
// Depends on sscu_pkg and the serial_stepper_command_unit RTL.
module serial_stepper_command_unit_tb;
  import sscu_pkg::*;

  localparam int BufferChars = 5;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [7:0] CH_VTAB = 8'h0B;
  localparam logic [7:0] CH_FFEED = 8'h0C;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam int PhaseItems = 130;
  localparam int TickCap = 300000;

  typedef enum logic [1:0] {
    SKIP_SPACE,
    AFTER_SIGN,
    IN_DIGITS,
    STOPPED
  } parse_phase_t;

  class motion_scoreboard;
    logic [15:0] max_steps;
    logic [15:0] half_period;
    logic [19:0] trigger_length;
    logic [2:0] kept_count;
    parse_phase_t phase;
    bit negative;
    logic [16:0] magnitude;
    logic [15:0] steps_left;
    logic [15:0] step_timer;
    bit step_out;
    bit dir_out;
    bit enable_out;
    logic [19:0] trigger_timer;
    bit trigger_out;
    result_t expected_outputs[$];
    int mismatches;

    function new();
      max_steps = MAX_STEPS_RST;
      half_period = HALF_PER_RST;
      trigger_length = TRIG_LEN_RST;
      clear_number();
      steps_left = '0;
      step_timer = '0;
      step_out = 1'b0;
      dir_out = 1'b0;
      enable_out = 1'b1;
      trigger_timer = '0;
      trigger_out = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] value);
      case (index)
        REG_MAX_STEPS: max_steps = value[15:0];
        REG_HALF_PER:  half_period = value[15:0];
        REG_TRIG_LEN:  trigger_length = value[19:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return steps_left != 0 || trigger_timer != 0;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function logic [15:0] half_ticks();
      return half_period == 0 ? 16'd1 : half_period;
    endfunction

    function void clear_number();
      kept_count = '0;
      phase = SKIP_SPACE;
      negative = 1'b0;
      magnitude = '0;
    endfunction

    function void absorb_char(logic [7:0] c);
      bit is_digit;
      bit is_space;
      int unsigned grown;
      is_digit = c >= CH_ZERO && c <= CH_NINE;
      is_space = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      if (phase == STOPPED) return;
      if (phase == SKIP_SPACE) begin
        if (is_space) return;
        if (c == CH_PLUS) begin
          phase = AFTER_SIGN;
          return;
        end
        if (c == CH_MINUS) begin
          negative = 1'b1;
          phase = AFTER_SIGN;
          return;
        end
      end
      if (is_digit) begin
        grown = magnitude * 10 + (c - CH_ZERO);
        magnitude = grown > MAG_MAX ? MAG_MAX : grown[16:0];
        phase = IN_DIGITS;
      end else begin
        phase = STOPPED;
      end
    endfunction

    function void close_number();
      if (magnitude <= max_steps) begin
        dir_out = (magnitude != 0 && !negative) ? 1'b0 : 1'b1;
        steps_left = magnitude[15:0];
        if (steps_left != 0) begin
          step_out = 1'b1;
          step_timer = half_ticks();
        end
      end
      clear_number();
    endfunction

    function void advance_tick();
      if (steps_left != 0) begin
        if (step_timer > 0) step_timer--;
        if (step_timer == 0) begin
          if (step_out) begin
            step_out = 1'b0;
            step_timer = half_ticks();
          end else begin
            steps_left--;
            if (steps_left != 0) begin
              step_out = 1'b1;
              step_timer = half_ticks();
            end
          end
        end
      end
      if (trigger_timer != 0) begin
        trigger_timer--;
        if (trigger_timer == 0) trigger_out = 1'b0;
      end
    endfunction

    function void take_event(logic [1:0] kind, logic [7:0] c);
      result_t e;
      e = '0;
      case (kind)
        KIND_BYTE: begin
          if (!busy()) begin
            e.tx_valid = 1'b1;
            e.tx_byte = c;
            e.byte_taken = 1'b1;
            case (c)
              CH_NEWLINE:       close_number();
              CH_D_LO, CH_D_UP: enable_out = 1'b0;
              CH_E_LO, CH_E_UP: enable_out = 1'b1;
              CH_T_LO, CH_T_UP: begin
                trigger_out = 1'b1;
                trigger_timer = trigger_length == 0 ? 20'd1 : trigger_length;
              end
              default: begin
                if (kept_count < BufferChars) begin
                  absorb_char(c);
                  kept_count++;
                end
              end
            endcase
          end
        end
        KIND_TICK: advance_tick();
        KIND_DONE: begin
          e.tx_valid = 1'b1;
          e.tx_byte = CH_ONE;
        end
        default: ;
      endcase
      e.step_level = step_out;
      e.dir_level = dir_out;
      e.enable_level = enable_out;
      e.trigger_level = trigger_out;
      e.busy_res = busy();
      expected_outputs.push_back(e);
    endfunction

    function string show(result_t r);
      return $sformatf({"tx_valid=%0b tx_byte=%02h taken=%0b step=%0b dir=%0b",
                        " en=%0b trig=%0b busy=%0b"},
                       r.tx_valid, r.tx_byte, r.byte_taken, r.step_level, r.dir_level,
                       r.enable_level, r.trigger_level, r.busy_res);
    endfunction

    function void check_result(logic [15:0] data);
      result_t got;
      result_t want;
      got = data[14:0];
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %s", show(got));
        return;
      end
      want = expected_outputs.pop_front();
      if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.byte_taken !== want.byte_taken || got.step_level !== want.step_level ||
          got.dir_level !== want.dir_level || got.enable_level !== want.enable_level ||
          got.trigger_level !== want.trigger_level || got.busy_res !== want.busy_res) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result differs at %0t", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  motion_scoreboard tracker = new();
  int sent_items = 0;
  bit quiet = 1'b0;
  bit allow_trigger = 1'b1;
  bit allow_noise_digits = 1'b1;
  logic [15:0] cur_max_steps = MAX_STEPS_RST;

  serial_stepper_command_unit #(
    .BUFFER_CHARS(BufferChars)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("serial_stepper_command_unit: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall = pick_gap();
      end
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_event(kind, c);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_event(KIND_BYTE, s[i]);
  endtask

  // Without noise digits, also drop whitespace and signs so that no noise
  // byte can shorten a later large number into an accepted long move.
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    bit bad;
    bit numeric;
    do begin
      c = 8'($urandom_range(0, 255));
      numeric = (c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE ||
                (c >= CH_TAB && c <= CH_CR) || c == CH_PLUS || c == CH_MINUS;
      bad = (!allow_trigger && (c == CH_T_LO || c == CH_T_UP)) ||
            (!allow_noise_digits && numeric);
    end while (bad);
    return c;
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VTAB;
      3: return CH_FFEED;
      default: return CH_CR;
    endcase
  endfunction

  // Tick the step train and trigger to idle; bytes, move-done and spare events are mixed in.
  task automatic run_ticks();
    int n;
    n = 0;
    while (tracker.busy() && n < TickCap) begin
      case ($urandom_range(0, 19))
        0: send_event(KIND_BYTE, 8'($urandom_range(0, 255)));
        1: send_event(KIND_DONE, 8'($urandom_range(0, 255)));
        2: send_event(KIND_SPARE, 8'($urandom_range(0, 255)));
        default: send_event(KIND_TICK, 8'($urandom_range(0, 255)));
      endcase
      n++;
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    tracker.set_reg(index, value);
    @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] steps, input logic [15:0] half,
                           input logic [19:0] trig);
    write_reg(REG_MAX_STEPS, {4'($urandom), steps});
    write_reg(REG_HALF_PER, {4'($urandom), half});
    write_reg(REG_TRIG_LEN, trig);
    cfg_we <= 1'b0;
    cur_max_steps = steps;
  endtask

  // Number line with random whitespace and sign; broken variants only where
  // max_steps keeps any accidental move short.
  task automatic send_number();
    int unsigned value;
    int unsigned small_cap;
    string digits;
    int sign_kind;
    int room;
    int lead;
    int flaw;
    int cut;
    small_cap = cur_max_steps < 12 ? cur_max_steps : 12;
    if ($urandom_range(0, 1)) value = $urandom_range(0, small_cap);
    else value = $urandom_range(cur_max_steps + 1, 99999);
    digits = $sformatf("%0d", value);
    sign_kind = $urandom_range(0, 2);
    if (cur_max_steps > 40 && digits.len() >= BufferChars) sign_kind = 0;
    room = BufferChars - digits.len() - (sign_kind != 0 ? 1 : 0);
    lead = room > 0 ? $urandom_range(0, room > 2 ? 2 : room) : 0;
    flaw = (cur_max_steps <= 40 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    cut = $urandom_range(0, digits.len());
    repeat (lead) send_event(KIND_BYTE, pick_space());
    if (sign_kind == 1) send_event(KIND_BYTE, CH_PLUS);
    if (sign_kind == 2) send_event(KIND_BYTE, CH_MINUS);
    for (int i = 0; i < digits.len(); i++) begin
      if (flaw == 1 && i == cut) send_event(KIND_BYTE, noise_char());
      send_event(KIND_BYTE, digits[i]);
    end
    if (flaw == 2) begin
      repeat ($urandom_range(1, 3)) send_event(KIND_BYTE, 8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if (flaw != 3) send_event(KIND_BYTE, CH_NEWLINE);
    run_ticks();
  endtask

  task automatic run_phase(input logic [15:0] steps, input logic [15:0] half,
                           input logic [19:0] trig, input bit no_idle);
    int start;
    run_ticks();
    wait_idle();
    configure(steps, half, trig);
    quiet = no_idle;
    allow_trigger = trig <= 64;
    allow_noise_digits = steps <= 40;
    start = sent_items;
    while (sent_items - start < PhaseItems) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: send_number();
        10: send_event(KIND_BYTE, $urandom_range(0, 1) ? CH_D_LO : CH_D_UP);
        11: send_event(KIND_BYTE, $urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
        12, 13: begin
          if (allow_trigger) begin
            send_event(KIND_BYTE, $urandom_range(0, 1) ? CH_T_LO : CH_T_UP);
            run_ticks();
          end
        end
        14: send_event(KIND_DONE, 8'($urandom_range(0, 255)));
        15: send_event(KIND_SPARE, 8'($urandom_range(0, 255)));
        16, 17: send_event(KIND_TICK, 8'($urandom_range(0, 255)));
        default: send_event(KIND_BYTE, noise_char());
      endcase
    end
    run_ticks();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values, idle events
    send_event(KIND_TICK, 8'hFF);
    send_event(KIND_DONE, 8'h00);
    send_event(KIND_SPARE, 8'hFF);
    send_text("D");
    send_text("E");
    send_event(KIND_BYTE, CH_NEWLINE);
    wait_idle();
    configure(16'd20, 16'd1, 20'd3);

    send_text("+3\n");
    run_ticks();
    send_text("-2\n");
    run_ticks();
    send_event(KIND_BYTE, CH_CR);
    send_event(KIND_BYTE, CH_VTAB);
    send_event(KIND_BYTE, CH_FFEED);
    send_text("\t1\n");
    run_ticks();
    send_text("1234567\n");
    send_text("4x\n");
    run_ticks();
    send_event(KIND_BYTE, CH_NUL);
    send_text("5\n");
    send_text("+\n-0\n");
    send_event(KIND_BYTE, 8'hFF);
    send_text("\n");
    send_text("t");
    send_text("e9");
    send_event(KIND_DONE, 8'h55);
    run_ticks();
    send_text("d");

    run_phase(16'd20, 16'd1, 20'd3, 1'b0);
    run_phase(16'd0, 16'd65535, 20'd5, 1'b0);
    run_phase(16'd65535, 16'd1, 20'hFFFFF, 1'b0);
    run_phase(16'd12, 16'd0, 20'd0, 1'b0);
    run_phase(16'd30, 16'd3, 20'd8, 1'b1);
    run_phase(16'd7, 16'd2, 20'd1, 1'b0);
    run_phase(16'($urandom_range(1, 40)), 16'($urandom_range(1, 3)),
              20'($urandom_range(1, 10)), 1'b0);
    run_phase(16'd40, 16'd1, 20'd2, 1'b1);

    wait_idle();
    repeat (8) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("serial_stepper_command_unit: match");
    end else begin
      $display("serial_stepper_command_unit: mismatch");
    end
    $finish;
  end

endmodule
